### rtl/sfe_pkg.sv
`default_nettype none
// ============================================================================
// sfe_pkg: shared types and constants of the framebuffer engine
// Word layouts, command and operation codes, default geometry.
// ============================================================================
package sfe_pkg;

    // default geometry
    localparam int FRAME_HEIGHT_DEF = 64;
    localparam int FRAME_WIDTH_DEF  = 128;
    localparam int SHIFT_STEP_DEF   = 4;

    // fixed sizes
    localparam int SPRITE_WIDE = 16;
    localparam int HALF_WIDE   = 64;
    localparam int ROW_SPAN    = 2 * HALF_WIDE;
    localparam int ROW_BITS    = 9;
    localparam int QUEUE_DEPTH = 2;

    // command codes on the input word
    localparam logic [2:0] CMD_SCROLL_DOWN  = 3'd0;
    localparam logic [2:0] CMD_SCROLL_RIGHT = 3'd1;
    localparam logic [2:0] CMD_SCROLL_LEFT  = 3'd2;
    localparam logic [2:0] CMD_SPRITE       = 3'd3;
    localparam logic [2:0] CMD_READ         = 3'd4;

    // operation codes handed from front to back
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_DOWN   = 3'd1;
    localparam logic [2:0] OP_RIGHT  = 3'd2;
    localparam logic [2:0] OP_LEFT   = 3'd3;
    localparam logic [2:0] OP_SPRITE = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  scroll_rows;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [15:0] sprite_bits;
        logic [3:0]  sprite_row;
        logic [5:0]  read_line;
        logic        read_half;
    } t_in_word;

    typedef struct packed {
        logic        collision;
        logic [63:0] pixel_data;
    } t_out_word;

    // classified command
    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  scroll_rows;
        logic [7:0]  pos_x;
        logic [15:0] sprite_bits;
        logic [8:0]  row;
        logic        row_ok;
        logic        clear_hit;
        logic        read_half;
    } t_task;

endpackage
`default_nettype wire

### rtl/superchip_framebuffer_engine.sv
`default_nettype none
// ============================================================================
// superchip_framebuffer_engine: 1-bit framebuffer with scroll and sprite draw
// Command queue in front, RAM-based executor behind, one result per command.
// ============================================================================
// Usage:
//   Input channel: drive i_in_word and raise push; the word is taken on an
//   edge where push is high and full is low. A two-entry queue holds words
//   while the executor is busy.
//   Result channel: while empty is low, o_out_word holds the oldest result;
//   raise pop to take it. Every command yields exactly one result word.
//   A sprite row or a read is a RAM read, then a modify step; a sprite
//   row writes back on the single write port. A scroll sweeps every row
//   through the RAM once. The executor takes the next command only once
//   it is back in idle.
//   Reset clears the queue, the collision flag and the per-row valid bits;
//   rows never written since reset read as unlit, so no clearing pass runs.
//   When the receiver stalls, the result register holds its word, the
//   executor waits, and the input queue fills and then raises full.
// ============================================================================
module superchip_framebuffer_engine #(
    parameter int FRAME_HEIGHT = sfe_pkg::FRAME_HEIGHT_DEF,
    parameter int FRAME_WIDTH  = sfe_pkg::FRAME_WIDTH_DEF,
    parameter int SHIFT_STEP   = sfe_pkg::SHIFT_STEP_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire sfe_pkg::t_in_word  i_in_word,
    output logic                    empty,
    input  wire logic               pop,
    output sfe_pkg::t_out_word      o_out_word
);

    sfe_pkg::t_task task_word;
    logic           task_valid;
    logic           task_take;

    // intake and classify
    sfe_front #(
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_in_word    (i_in_word),
        .o_task       (task_word),
        .o_task_valid (task_valid),
        .i_task_take  (task_take)
    );

    // execute against the framebuffer
    sfe_back #(
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .FRAME_WIDTH  (FRAME_WIDTH),
        .SHIFT_STEP   (SHIFT_STEP)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task       (task_word),
        .i_task_valid (task_valid),
        .o_task_take  (task_take),
        .pop          (pop),
        .empty        (empty),
        .o_out_word   (o_out_word)
    );

`ifndef SYNTH
    // executor only takes a task the queue really holds
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        task_take |-> task_valid)
        else $error("task taken from an empty queue");

    // a full queue always offers a task
    a_full_offers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> task_valid)
        else $error("queue full but no task offered");

    // after an accepted word the queue offers a task next cycle
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> task_valid)
        else $error("accepted word not visible to executor");
`endif

endmodule
`default_nettype wire

### rtl/sfe_ram.sv
`default_nettype none
// ============================================================================
// sfe_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
module sfe_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### rtl/sfe_front.sv
`default_nettype none
// ============================================================================
// sfe_front: command intake
// Decodes each input word into a task and holds it in a short queue.
// ============================================================================
module sfe_front #(
    parameter int FRAME_HEIGHT = sfe_pkg::FRAME_HEIGHT_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire sfe_pkg::t_in_word i_in_word,
    output sfe_pkg::t_task        o_task,
    output logic                  o_task_valid,
    input  wire logic             i_task_take
);

    localparam int RB = sfe_pkg::ROW_BITS;
    localparam int QD = sfe_pkg::QUEUE_DEPTH;
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW = $clog2(QD + 1);

    sfe_pkg::t_task   cls;
    logic [RB-1:0]    draw_row;
    sfe_pkg::t_task   r_slot [QD];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             accept;

    // classify the incoming word
    always_comb begin
        draw_row        = RB'(i_in_word.pos_y) + RB'(i_in_word.sprite_row);
        cls             = '0;
        cls.scroll_rows = i_in_word.scroll_rows;
        cls.pos_x       = i_in_word.pos_x;
        cls.sprite_bits = i_in_word.sprite_bits;
        cls.read_half   = i_in_word.read_half;
        cls.clear_hit   = (i_in_word.sprite_row == 4'd0);
        cls.row         = draw_row;
        unique case (i_in_word.command)
            sfe_pkg::CMD_SCROLL_DOWN: begin
                cls.op = (i_in_word.scroll_rows == 4'd0) ? sfe_pkg::OP_NOP : sfe_pkg::OP_DOWN;
            end
            sfe_pkg::CMD_SCROLL_RIGHT: cls.op = sfe_pkg::OP_RIGHT;
            sfe_pkg::CMD_SCROLL_LEFT:  cls.op = sfe_pkg::OP_LEFT;
            sfe_pkg::CMD_SPRITE:       cls.op = sfe_pkg::OP_SPRITE;
            sfe_pkg::CMD_READ: begin
                cls.op  = sfe_pkg::OP_READ;
                cls.row = RB'(i_in_word.read_line);
            end
            default:                   cls.op = sfe_pkg::OP_NOP;
        endcase
        cls.row_ok = (cls.row < RB'(FRAME_HEIGHT));
    end

    assign full         = (r_count == CW'(QD));
    assign accept       = push && !full;
    assign o_task_valid = (r_count != '0);
    assign o_task       = r_slot[r_rd_ptr];

    // advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (accept) begin
            n_wr_ptr = (r_wr_ptr == PW'(QD - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_task_take) begin
            n_rd_ptr = (r_rd_ptr == PW'(QD - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({accept, i_task_take})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // hold the word in its slot
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot[r_wr_ptr] <= cls;
        end
    end

endmodule
`default_nettype wire

### rtl/sfe_back.sv
`default_nettype none
// ============================================================================
// sfe_back: command execution
// Runs tasks against the row RAM: sprite row XOR, half-row read, row sweeps
// for scrolling. Drives the result register.
// ============================================================================
module sfe_back #(
    parameter int FRAME_HEIGHT = sfe_pkg::FRAME_HEIGHT_DEF,
    parameter int FRAME_WIDTH  = sfe_pkg::FRAME_WIDTH_DEF,
    parameter int SHIFT_STEP   = sfe_pkg::SHIFT_STEP_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sfe_pkg::t_task    i_task,
    input  wire logic              i_task_valid,
    output logic                   o_task_take,
    input  wire logic              pop,
    output logic                   empty,
    output sfe_pkg::t_out_word     o_out_word
);

    localparam int AW  = $clog2(FRAME_HEIGHT);
    localparam int CW  = $clog2(FRAME_HEIGHT + 1);
    localparam int SW  = sfe_pkg::SPRITE_WIDE;
    localparam int MW  = FRAME_WIDTH + SW;
    localparam int RS  = sfe_pkg::ROW_SPAN;
    localparam int HW  = sfe_pkg::HALF_WIDE;
    localparam int PAD = RS - FRAME_WIDTH;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MODIFY = 2'd1;
    localparam logic [1:0] ST_SWEEP  = 2'd2;

    logic [1:0]             r_state, n_state;
    sfe_pkg::t_task         r_task, n_task;
    logic [CW-1:0]          r_idx, n_idx;
    logic                   r_wb_act;
    logic [AW-1:0]          r_wb_row;
    logic                   r_wb_src_ok;
    logic [FRAME_HEIGHT-1:0] r_valid;
    logic                   r_rd_valid;
    logic                   r_hit, n_hit;
    logic                   r_out_valid, n_out_valid;
    sfe_pkg::t_out_word     r_out_word, n_out_word;

    logic                   out_free;
    logic                   take;
    logic [FRAME_WIDTH-1:0] ram_q;
    logic [FRAME_WIDTH-1:0] rd_row;
    logic [AW-1:0]          sweep_row;
    logic                   sweep_rd;
    logic                   down_ok;
    logic [AW-1:0]          raddr;
    logic [MW-1:0]          wide;
    logic [FRAME_WIDTH-1:0] mask;
    logic                   hit_base;
    logic                   draw_hit;
    logic [RS-1:0]          pad;
    logic [HW-1:0]          half_data;
    logic [FRAME_WIDTH-1:0] sweep_wdata;
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [FRAME_WIDTH-1:0] wdata;

    assign out_free    = !r_out_valid || pop;
    assign take        = (r_state == ST_IDLE) && i_task_valid && out_free;
    assign o_task_take = take;
    assign empty       = !r_out_valid;
    assign o_out_word  = r_out_word;

    // never-written rows read as unlit
    assign rd_row = r_rd_valid ? ram_q : '0;

    // sweep walks rows from the bottom up so scroll-down sources stay intact
    assign sweep_row = AW'(FRAME_HEIGHT - 1) - r_idx[AW-1:0];
    assign sweep_rd  = (r_state == ST_SWEEP) && (r_idx != CW'(FRAME_HEIGHT));
    assign down_ok   = (sweep_row >= AW'(r_task.scroll_rows));

    // read address: task row on intake, source row while sweeping
    always_comb begin
        if (r_state == ST_IDLE) begin
            raddr = i_task.row_ok ? i_task.row[AW-1:0] : '0;
        end else if (r_task.op == sfe_pkg::OP_DOWN) begin
            raddr = sweep_row - AW'(r_task.scroll_rows);
        end else begin
            raddr = sweep_row;
        end
    end

    // sprite mask: column c sits at bit FRAME_WIDTH-1-c
    assign wide     = {r_task.sprite_bits, {FRAME_WIDTH{1'b0}}} >> r_task.pos_x;
    assign mask     = wide[MW-1:SW];
    assign hit_base = r_task.clear_hit ? 1'b0 : r_hit;
    assign draw_hit = hit_base | (r_task.row_ok && (|(rd_row & mask)));

    // half-row select on a row padded out to full span
    assign pad       = RS'(rd_row) << PAD;
    assign half_data = r_task.read_half ? pad[HW-1:0] : pad[RS-1:HW];

    // row written back during a sweep
    always_comb begin
        if (r_task.op == sfe_pkg::OP_RIGHT) begin
            sweep_wdata = rd_row >> SHIFT_STEP;
        end else if (r_task.op == sfe_pkg::OP_LEFT) begin
            sweep_wdata = rd_row << SHIFT_STEP;
        end else begin
            sweep_wdata = r_wb_src_ok ? rd_row : '0;
        end
    end

    // write port
    always_comb begin
        we    = 1'b0;
        waddr = r_task.row[AW-1:0];
        wdata = rd_row ^ mask;
        if (r_state == ST_SWEEP) begin
            we    = r_wb_act;
            waddr = r_wb_row;
            wdata = sweep_wdata;
        end else if (r_state == ST_MODIFY) begin
            we = (r_task.op == sfe_pkg::OP_SPRITE) && r_task.row_ok;
        end
    end

    sfe_ram #(
        .WIDTH (FRAME_WIDTH),
        .DEPTH (FRAME_HEIGHT)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_task      = r_task;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && !pop;
        n_out_word  = r_out_word;
        unique case (r_state)
            ST_IDLE: begin
                if (take) begin
                    n_task = i_task;
                    n_idx  = '0;
                    priority if (i_task.op == sfe_pkg::OP_SPRITE ||
                                 i_task.op == sfe_pkg::OP_READ) begin
                        n_state = ST_MODIFY;
                    end else if (i_task.op == sfe_pkg::OP_DOWN ||
                                 i_task.op == sfe_pkg::OP_RIGHT ||
                                 i_task.op == sfe_pkg::OP_LEFT) begin
                        n_state = ST_SWEEP;
                    end else begin
                        n_out_valid           = 1'b1;
                        n_out_word.collision  = r_hit;
                        n_out_word.pixel_data = '0;
                    end
                end
            end
            ST_MODIFY: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                if (r_task.op == sfe_pkg::OP_SPRITE) begin
                    n_hit                 = draw_hit;
                    n_out_word.collision  = draw_hit;
                    n_out_word.pixel_data = '0;
                end else begin
                    n_out_word.collision  = r_hit;
                    n_out_word.pixel_data = r_task.row_ok ? half_data : '0;
                end
            end
            ST_SWEEP: begin
                if (sweep_rd) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state               = ST_IDLE;
                    n_out_valid           = 1'b1;
                    n_out_word.collision  = r_hit;
                    n_out_word.pixel_data = '0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_rd_valid  <= 1'b0;
            r_wb_act    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
            r_rd_valid  <= r_valid[raddr];
            r_wb_act    <= sweep_rd;
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_task      <= n_task;
        r_idx       <= n_idx;
        r_out_word  <= n_out_word;
        r_wb_row    <= sweep_row;
        r_wb_src_ok <= (r_task.op != sfe_pkg::OP_DOWN) || down_ok;
    end

endmodule
`default_nettype wire

### bench/superchip_framebuffer_engine_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// superchip_framebuffer_engine_tb: self-checking bench for the framebuffer engine
// Drives scroll, sprite-row, read and spare commands through the input queue,
// tracks the expected picture and collision flag in a local copy of the
// framebuffer, and compares every result word in order. Both sides idle at
// random, and the receiver holds off once for a long stretch so the engine
// backs up and raises full.
// ============================================================================
module superchip_framebuffer_engine_tb;

    localparam int FRAME_HEIGHT = sfe_pkg::FRAME_HEIGHT_DEF;
    localparam int FRAME_WIDTH  = sfe_pkg::FRAME_WIDTH_DEF;
    localparam int SHIFT_STEP   = sfe_pkg::SHIFT_STEP_DEF;

    // spare command codes that the engine must ignore
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    localparam int WORDS_WANTED = 700;
    localparam int IDLE_PCT     = 19;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 300;

    // ------------------------------------------------------------------------
    // Framebuffer tracker: expected picture, collision flag, pending results
    // ------------------------------------------------------------------------
    class framebuffer_tracker;
        bit [sfe_pkg::ROW_SPAN-1:0] rows [FRAME_HEIGHT];
        bit                         hit;
        sfe_pkg::t_out_word         expected_words[$];
        int                         failures;

        function new();
            foreach (rows[r]) rows[r] = '0;
            hit      = 1'b0;
            failures = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // apply one accepted command and queue the word it must produce
        function void apply_command(sfe_pkg::t_in_word w);
            sfe_pkg::t_out_word         res;
            bit [sfe_pkg::ROW_SPAN-1:0] mask;
            bit [sfe_pkg::ROW_SPAN-1:0] visible;
            int unsigned                line;
            int unsigned                col;
            res     = '0;
            visible = ~({sfe_pkg::ROW_SPAN{1'b1}} >> FRAME_WIDTH);
            case (w.command)
                sfe_pkg::CMD_SCROLL_DOWN: begin
                    // shift rows down, fill the top with unlit rows
                    if (w.scroll_rows != 0) begin
                        for (int r = FRAME_HEIGHT - 1; r >= 0; r--) begin
                            if (r >= int'(w.scroll_rows))
                                rows[r] = rows[r - int'(w.scroll_rows)];
                            else
                                rows[r] = '0;
                        end
                    end
                end
                sfe_pkg::CMD_SCROLL_RIGHT: begin
                    foreach (rows[r]) rows[r] = (rows[r] >> SHIFT_STEP) & visible;
                end
                sfe_pkg::CMD_SCROLL_LEFT: begin
                    foreach (rows[r]) rows[r] = (rows[r] << SHIFT_STEP) & visible;
                end
                sfe_pkg::CMD_SPRITE: begin
                    // a new sprite starts with a clean collision flag
                    if (w.sprite_row == 0) hit = 1'b0;
                    line = int'(w.pos_y) + int'(w.sprite_row);
                    if (line < FRAME_HEIGHT) begin
                        mask = '0;
                        for (int k = 0; k < sfe_pkg::SPRITE_WIDE; k++) begin
                            col = int'(w.pos_x) + k;
                            if (w.sprite_bits[sfe_pkg::SPRITE_WIDE - 1 - k] &&
                                col < FRAME_WIDTH)
                                mask[sfe_pkg::ROW_SPAN - 1 - col] = 1'b1;
                        end
                        if ((rows[line] & mask) != '0) hit = 1'b1;
                        rows[line] ^= mask;
                    end
                end
                sfe_pkg::CMD_READ: begin
                    if (w.read_line < FRAME_HEIGHT) begin
                        if (w.read_half)
                            res.pixel_data =
                                rows[w.read_line][sfe_pkg::HALF_WIDE-1:0];
                        else
                            res.pixel_data =
                                rows[w.read_line][sfe_pkg::ROW_SPAN-1:sfe_pkg::HALF_WIDE];
                    end
                end
                default: ;
            endcase
            res.collision = hit;
            expected_words.push_back(res);
        endfunction

        // compare one result word with the oldest expectation
        function void check_result(sfe_pkg::t_out_word got);
            sfe_pkg::t_out_word want;
            if (expected_words.size() == 0) begin
                if (failures < 10)
                    $display("unexpected result word: collision=%0b data=%h",
                             got.collision, got.pixel_data);
                failures++;
                return;
            end
            want = expected_words.pop_front();
            if (got.collision !== want.collision || got.pixel_data !== want.pixel_data) begin
                if (failures < 10)
                    $display({"result word wrong: expected collision=%0b data=%h,",
                              " got collision=%0b data=%h"},
                             want.collision, want.pixel_data,
                             got.collision, got.pixel_data);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, ports, instance
    // ------------------------------------------------------------------------
    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               push      = 1'b0;
    logic               pop       = 1'b0;
    logic               idle_on   = 1'b1;
    sfe_pkg::t_in_word  i_in_word = '0;
    logic               full;
    logic               empty;
    sfe_pkg::t_out_word o_out_word;

    framebuffer_tracker tracker = new();
    int                 words_sent = 0;

    always #5 i_clk = ~i_clk;

    superchip_framebuffer_engine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    function automatic sfe_pkg::t_in_word random_word();
        bit [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(sfe_pkg::t_in_word)-1:0];
    endfunction

    // offer one word, optionally idling first, and hold it until accepted
    task automatic put_word(input sfe_pkg::t_in_word w);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (full);
        tracker.apply_command(w);
        if (w.command <= sfe_pkg::CMD_READ) words_sent++;
    endtask

    task automatic put_plain(input logic [2:0] cmd, input logic [3:0] n);
        sfe_pkg::t_in_word w;
        w             = random_word();
        w.command     = cmd;
        w.scroll_rows = n;
        put_word(w);
    endtask

    task automatic put_sprite(input logic [7:0] x, input logic [7:0] y,
                              input logic [15:0] bits, input logic [3:0] r);
        sfe_pkg::t_in_word w;
        w             = random_word();
        w.command     = sfe_pkg::CMD_SPRITE;
        w.pos_x       = x;
        w.pos_y       = y;
        w.sprite_bits = bits;
        w.sprite_row  = r;
        put_word(w);
    endtask

    task automatic put_read(input logic [5:0] line, input logic half);
        sfe_pkg::t_in_word w;
        w           = random_word();
        w.command   = sfe_pkg::CMD_READ;
        w.read_line = line;
        w.read_half = half;
        put_word(w);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random pops, one long hold-off to back up the engine
    // ------------------------------------------------------------------------
    int results_taken = 0;
    int hold_left     = 0;
    bit held_once     = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                tracker.check_result(o_out_word);
                results_taken++;
            end
            if (results_taken == HOLD_AFTER && !held_once) begin
                hold_left = HOLD_CYCLES;
                held_once = 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            pop <= (hold_left == 0) && !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int         kind;
        int         first_row;
        int         last_row;
        logic [7:0] x;
        logic [7:0] y;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fresh picture reads back unlit
        put_read(6'd0, 1'b0);
        put_read(6'd0, 1'b1);
        // draw, read back, then erase the same pixels for a collision
        put_sprite(8'd0, 8'd0, 16'hffff, 4'd0);
        put_read(6'd0, 1'b0);
        put_sprite(8'd0, 8'd0, 16'hffff, 4'd0);
        // a later row keeps the flag of the sprite in progress
        put_sprite(8'd0, 8'd0, 16'h8001, 4'd1);
        // clip at the right edge, fully off to the right, off the bottom
        put_sprite(8'd120, 8'd0, 16'hffff, 4'd2);
        put_sprite(8'd255, 8'd0, 16'hffff, 4'd3);
        put_sprite(8'd60, 8'd63, 16'ha5a5, 4'd0);
        put_sprite(8'd0, 8'd255, 16'hffff, 4'd15);
        put_sprite(8'd0, 8'd60, 16'h0000, 4'd4);
        put_read(6'd63, 1'b0);
        put_read(6'd63, 1'b1);
        put_read(6'd2, 1'b1);
        // side scrolls drop pixels off the edges
        put_plain(sfe_pkg::CMD_SCROLL_RIGHT, 4'd0);
        put_read(6'd63, 1'b0);
        put_plain(sfe_pkg::CMD_SCROLL_LEFT, 4'd0);
        put_plain(sfe_pkg::CMD_SCROLL_LEFT, 4'd0);
        put_read(6'd2, 1'b1);
        // scroll down by nothing, by one, by the most the field allows
        put_plain(sfe_pkg::CMD_SCROLL_DOWN, 4'd0);
        put_plain(sfe_pkg::CMD_SCROLL_DOWN, 4'd1);
        put_read(6'd3, 1'b1);
        put_plain(sfe_pkg::CMD_SCROLL_DOWN, 4'd15);
        put_read(6'd18, 1'b1);
        // spare commands change nothing
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            put_plain(3'(c), 4'($urandom));

        // random part: mostly whole sprites, with reads, scrolls and noise
        while (words_sent < WORDS_WANTED) begin
            idle_on <= !(words_sent >= 250 && words_sent < 400);
            kind = $urandom_range(99);
            if (kind < 55) begin
                x = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 127)) : 8'($urandom);
                y = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 63)) : 8'($urandom);
                // now and then start a sprite in the middle
                first_row = ($urandom_range(99) < 10) ? $urandom_range(1, 15) : 0;
                last_row  = $urandom_range(first_row, 15);
                for (int r = first_row; r <= last_row; r++)
                    put_sprite(x, y, 16'($urandom), 4'(r));
            end else if (kind < 80) begin
                repeat ($urandom_range(1, 4))
                    put_read(6'($urandom), 1'($urandom));
            end else if (kind < 92) begin
                put_plain(3'($urandom_range(sfe_pkg::CMD_SCROLL_DOWN,
                                            sfe_pkg::CMD_SCROLL_LEFT)),
                          4'($urandom));
            end else if (kind < 96) begin
                put_plain(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                          4'($urandom));
            end else begin
                put_word(random_word());
            end
        end

        // drain, then watch for stray results
        push    <= 1'b0;
        idle_on <= 1'b1;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (FRAME_HEIGHT + 16) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
rtl/sfe_pkg.sv
rtl/sfe_ram.sv
rtl/sfe_front.sv
rtl/sfe_back.sv
rtl/superchip_framebuffer_engine.sv
bench/superchip_framebuffer_engine_tb.sv
